// ===== rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg: shared types, constants and helpers
// Stage map, register codes, rounding and saturation for the transform
// compose pipeline.
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int NSQ        = 30;
   localparam int NDIV       = 15;
   localparam int CARRY_FIRST = 2;
   localparam int TRANS_ST   = 4;
   localparam int SQ_FIRST   = 4;
   localparam int PREP_ST    = SQ_FIRST + NSQ;
   localparam int DIV_FIRST  = PREP_ST + 1;
   localparam int OUT_ST     = DIV_FIRST + NDIV;
   localparam int NST        = OUT_ST + 1;

   localparam int SUM_W  = 2 * NSQ;
   localparam int LEN_W  = NSQ;
   localparam int DD_W   = LEN_W + NDIV;
   localparam int QMAG_W = 29;

   localparam logic [2:0] REG_PTX    = 3'd0;
   localparam logic [2:0] REG_PTY    = 3'd1;
   localparam logic [2:0] REG_PTZ    = 3'd2;
   localparam logic [2:0] REG_PQX    = 3'd3;
   localparam logic [2:0] REG_PQY    = 3'd4;
   localparam logic [2:0] REG_PQZ    = 3'd5;
   localparam logic [2:0] REG_PQW    = 3'd6;
   localparam logic [2:0] REG_PSCALE = 3'd7;

   localparam logic [LEN_W-1:0] ZERO_TOL = LEN_W'(17);
   localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

   typedef struct packed {
      logic [2:0][31:0]        wt;
      logic [2:0][15:0]        ws;
      logic [3:0][15:0]        qa;
      logic [3:0]              qneg;
      logic [3:0][QMAG_W-1:0]  qmag;
      logic                    big;
   } carry_type;

   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned s);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'h7fff;
      else if (v < -64'sd32768) return 16'h8000;
      else return v[15:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      else if (v < -64'sd2147483648) return 32'h80000000;
      else return v[31:0];
   endfunction

endpackage

// ===== rtl/trs_isqrt.sv =====
// ----------------------------------------------------------------------------
// trs_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(x)) after the last stage.
// ----------------------------------------------------------------------------
module trs_isqrt (
   input  logic                         clock,
   input  logic [trs_pkg::NSQ-1:0]      en,
   input  logic [trs_pkg::SUM_W-1:0]    x,
   output logic [trs_pkg::LEN_W-1:0]    root
);
   import trs_pkg::*;

   logic [SUM_W-1:0] x_ff [NSQ];
   logic [SUM_W-1:0] r_ff [NSQ];
   logic [SUM_W-1:0] x_in [NSQ];
   logic [SUM_W-1:0] r_in [NSQ];

   always_comb begin
      for (int k = 0; k < NSQ; k++) begin
         logic [SUM_W-1:0] xi, ri, bt, t;
         xi = (k == 0) ? x : x_ff[(k == 0) ? 0 : k - 1];
         ri = (k == 0) ? '0 : r_ff[(k == 0) ? 0 : k - 1];
         bt = SUM_W'(1) << (2 * (NSQ - 1 - k));
         t  = ri + bt;
         if (xi >= t) begin
            x_in[k] = xi - t;
            r_in[k] = (ri >> 1) + bt;
         end else begin
            x_in[k] = xi;
            r_in[k] = ri >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSQ; k++) begin
         if (en[k]) begin
            x_ff[k] <= x_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[NSQ-1][LEN_W-1:0];

endmodule

// ===== rtl/trs_qdiv.sv =====
// ----------------------------------------------------------------------------
// trs_qdiv: pipelined restoring divider, four lanes
// One quotient bit per stage for each quaternion part, shared divisor.
// ----------------------------------------------------------------------------
module trs_qdiv (
   input  logic                                clock,
   input  logic [trs_pkg::NDIV-1:0]            en,
   input  logic [3:0][trs_pkg::DD_W-1:0]       dd,
   input  logic [trs_pkg::LEN_W-1:0]           len,
   output logic [3:0][trs_pkg::NDIV-1:0]       quo
);
   import trs_pkg::*;

   logic [3:0][DD_W-1:0] rem_ff [NDIV];
   logic [3:0][NDIV-1:0] q_ff   [NDIV];
   logic [LEN_W-1:0]     l_ff   [NDIV];
   logic [3:0][DD_W-1:0] rem_in [NDIV];
   logic [3:0][NDIV-1:0] q_in   [NDIV];
   logic [LEN_W-1:0]     l_in   [NDIV];

   always_comb begin
      for (int k = 0; k < NDIV; k++) begin
         logic [3:0][DD_W-1:0] ri;
         logic [3:0][NDIV-1:0] qi;
         logic [DD_W-1:0]      dv;
         ri      = (k == 0) ? dd  : rem_ff[(k == 0) ? 0 : k - 1];
         qi      = (k == 0) ? '0  : q_ff[(k == 0) ? 0 : k - 1];
         l_in[k] = (k == 0) ? len : l_ff[(k == 0) ? 0 : k - 1];
         dv      = DD_W'(l_in[k]) << (NDIV - 1 - k);
         for (int i = 0; i < 4; i++) begin
            if (ri[i] >= dv) begin
               ri[i] = ri[i] - dv;
               qi[i][NDIV - 1 - k] = 1'b1;
            end
         end
         rem_in[k] = ri;
         q_in[k]   = qi;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NDIV; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            l_ff[k]   <= l_in[k];
         end
      end
   end

   assign quo = q_ff[NDIV-1];

endmodule

// ===== rtl/trs_transform_compose.sv =====
// ----------------------------------------------------------------------------
// trs_transform_compose: child transform composed into parent space
// Parent translation, rotation and scale sit in APB registers; each child
// transaction yields one world transaction.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle while no result is stalled.
// The pipeline depth is set by the 30-stage square root of the quaternion
// length and the 15-stage divider that normalizes it; translation and scale
// results ride alongside. A stalled result holds only the stages behind it
// that are occupied, so empty stages keep taking transactions.
module trs_transform_compose (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_child_tx,
   input  logic signed [31:0] req_child_ty,
   input  logic signed [31:0] req_child_tz,
   input  logic signed [15:0] req_child_qx,
   input  logic signed [15:0] req_child_qy,
   input  logic signed [15:0] req_child_qz,
   input  logic signed [15:0] req_child_qw,
   input  logic signed [15:0] req_child_sx,
   input  logic signed [15:0] req_child_sy,
   input  logic signed [15:0] req_child_sz,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_world_tx,
   output logic signed [31:0] rsp_world_ty,
   output logic signed [31:0] rsp_world_tz,
   output logic signed [15:0] rsp_world_qx,
   output logic signed [15:0] rsp_world_qy,
   output logic signed [15:0] rsp_world_qz,
   output logic signed [15:0] rsp_world_qw,
   output logic signed [15:0] rsp_world_sx,
   output logic signed [15:0] rsp_world_sy,
   output logic signed [15:0] rsp_world_sz,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);
   import trs_pkg::*;

   logic signed [31:0] ptx_ff, pty_ff, ptz_ff;
   logic signed [15:0] px_ff, py_ff, pz_ff, pw_ff;
   logic [47:0]        pscale_ff;

   logic signed [31:0] pt [3];
   logic signed [15:0] ps [3];
   logic signed [31:0] ct [3];
   logic signed [15:0] cs [3];

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   logic signed [31:0] hp_ff [16];
   logic signed [31:0] hp_in [16];
   logic signed [47:0] tvp_ff [3];
   logic signed [47:0] tvp_in [3];
   logic signed [31:0] sp_ff [3];
   logic signed [31:0] sp_in [3];
   logic signed [31:0] mp_ff [9];
   logic signed [31:0] mp_in [9];

   logic signed [63:0] hs [4];
   logic signed [63:0] me [9];
   logic signed [29:0] q24_ff [4];
   logic signed [29:0] q24_in [4];
   logic signed [39:0] tv_ff [3];
   logic signed [39:0] tv_in [3];
   logic signed [23:0] m_ff [9];
   logic signed [23:0] m_in [9];
   logic [15:0]        ws_ff [3];
   logic [15:0]        ws_in [3];

   logic [57:0]        sq_ff [4];
   logic [57:0]        sq_in [4];
   logic signed [44:0] pl_ff [9];
   logic signed [44:0] pl_in [9];
   logic signed [43:0] ph_ff [9];
   logic signed [43:0] ph_in [9];

   logic [SUM_W-1:0]   ssum_ff;
   logic [SUM_W-1:0]   ssum_in;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] acc_in [3];

   carry_type carry_ff [CARRY_FIRST:OUT_ST];
   carry_type carry_in [CARRY_FIRST:OUT_ST];

   logic [LEN_W-1:0]      root;
   logic [LEN_W-1:0]      len_ff;
   logic [3:0][DD_W-1:0]  dd_ff;
   logic [3:0][DD_W-1:0]  dd_in;
   logic [3:0][NDIV-1:0]  quo;
   logic [15:0]           wq_ff [4];
   logic [15:0]           wq_in [4];

   assign pt[0] = ptx_ff;
   assign pt[1] = pty_ff;
   assign pt[2] = ptz_ff;
   assign ps[0] = $signed(pscale_ff[15:0]);
   assign ps[1] = $signed(pscale_ff[31:16]);
   assign ps[2] = $signed(pscale_ff[47:32]);
   assign ct[0] = req_child_tx;
   assign ct[1] = req_child_ty;
   assign ct[2] = req_child_tz;
   assign cs[0] = req_child_sx;
   assign cs[1] = req_child_sy;
   assign cs[2] = req_child_sz;

   // configuration registers
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptx_ff    <= '0;
         pty_ff    <= '0;
         ptz_ff    <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         pz_ff     <= '0;
         pw_ff     <= 16'sd16384;
         pscale_ff <= 48'h010001000100;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[5:3])
            REG_PTX:    ptx_ff    <= $signed(pwdata[31:0]);
            REG_PTY:    pty_ff    <= $signed(pwdata[31:0]);
            REG_PTZ:    ptz_ff    <= $signed(pwdata[31:0]);
            REG_PQX:    px_ff     <= $signed(pwdata[15:0]);
            REG_PQY:    py_ff     <= $signed(pwdata[15:0]);
            REG_PQZ:    pz_ff     <= $signed(pwdata[15:0]);
            REG_PQW:    pw_ff     <= $signed(pwdata[15:0]);
            REG_PSCALE: pscale_ff <= pwdata[47:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         REG_PTX:    prdata = {32'b0, ptx_ff};
         REG_PTY:    prdata = {32'b0, pty_ff};
         REG_PTZ:    prdata = {32'b0, ptz_ff};
         REG_PQX:    prdata = {48'b0, px_ff};
         REG_PQY:    prdata = {48'b0, py_ff};
         REG_PQZ:    prdata = {48'b0, pz_ff};
         REG_PQW:    prdata = {48'b0, pw_ff};
         REG_PSCALE: prdata = {16'b0, pscale_ff};
         default:    prdata = '0;
      endcase
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || !rsp_stall;
      for (int s = NST - 2; s >= 0; s--) en[s] = !v_ff[s] || en[s+1];
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int s = 1; s < NST; s++) begin
            if (en[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // stage 0: products
   always_comb begin
      hp_in[0]  = px_ff * req_child_qw;
      hp_in[1]  = req_child_qx * pw_ff;
      hp_in[2]  = py_ff * req_child_qz;
      hp_in[3]  = pz_ff * req_child_qy;
      hp_in[4]  = py_ff * req_child_qw;
      hp_in[5]  = req_child_qy * pw_ff;
      hp_in[6]  = pz_ff * req_child_qx;
      hp_in[7]  = px_ff * req_child_qz;
      hp_in[8]  = pz_ff * req_child_qw;
      hp_in[9]  = req_child_qz * pw_ff;
      hp_in[10] = px_ff * req_child_qy;
      hp_in[11] = py_ff * req_child_qx;
      hp_in[12] = pw_ff * req_child_qw;
      hp_in[13] = px_ff * req_child_qx;
      hp_in[14] = py_ff * req_child_qy;
      hp_in[15] = pz_ff * req_child_qz;
      mp_in[0]  = px_ff * px_ff;
      mp_in[1]  = py_ff * py_ff;
      mp_in[2]  = pz_ff * pz_ff;
      mp_in[3]  = px_ff * py_ff;
      mp_in[4]  = px_ff * pz_ff;
      mp_in[5]  = py_ff * pz_ff;
      mp_in[6]  = pw_ff * px_ff;
      mp_in[7]  = pw_ff * py_ff;
      mp_in[8]  = pw_ff * pz_ff;
      for (int i = 0; i < 3; i++) begin
         tvp_in[i] = ct[i] * ps[i];
         sp_in[i]  = ps[i] * cs[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hp_ff  <= hp_in;
         mp_ff  <= mp_in;
         tvp_ff <= tvp_in;
         sp_ff  <= sp_in;
      end
   end

   // stage 1: sums and rounding
   always_comb begin
      hs[0] = 64'(hp_ff[0]) + 64'(hp_ff[1]) + 64'(hp_ff[2]) - 64'(hp_ff[3]);
      hs[1] = 64'(hp_ff[4]) + 64'(hp_ff[5]) + 64'(hp_ff[6]) - 64'(hp_ff[7]);
      hs[2] = 64'(hp_ff[8]) + 64'(hp_ff[9]) + 64'(hp_ff[10]) - 64'(hp_ff[11]);
      hs[3] = 64'(hp_ff[12]) - (64'(hp_ff[13]) + 64'(hp_ff[14]) + 64'(hp_ff[15]));
      me[0] = ONE_Q28 - 64'sd2 * (64'(mp_ff[1]) + 64'(mp_ff[2]));
      me[1] = 64'sd2 * (64'(mp_ff[3]) - 64'(mp_ff[8]));
      me[2] = 64'sd2 * (64'(mp_ff[4]) + 64'(mp_ff[7]));
      me[3] = 64'sd2 * (64'(mp_ff[3]) + 64'(mp_ff[8]));
      me[4] = ONE_Q28 - 64'sd2 * (64'(mp_ff[0]) + 64'(mp_ff[2]));
      me[5] = 64'sd2 * (64'(mp_ff[5]) - 64'(mp_ff[6]));
      me[6] = 64'sd2 * (64'(mp_ff[4]) - 64'(mp_ff[7]));
      me[7] = 64'sd2 * (64'(mp_ff[5]) + 64'(mp_ff[6]));
      me[8] = ONE_Q28 - 64'sd2 * (64'(mp_ff[0]) + 64'(mp_ff[1]));
      for (int i = 0; i < 4; i++) q24_in[i] = 30'(rnd_shr(hs[i], 4));
      for (int k = 0; k < 9; k++) m_in[k] = 24'(rnd_shr(me[k], 10));
      for (int i = 0; i < 3; i++) begin
         tv_in[i] = 40'(rnd_shr(64'(tvp_ff[i]), 8));
         ws_in[i] = sat16(rnd_shr(64'(sp_ff[i]), 8));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         q24_ff <= q24_in;
         m_ff   <= m_in;
         tv_ff  <= tv_in;
         ws_ff  <= ws_in;
      end
   end

   // stage 2: squares and split matrix products
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic signed [59:0] sqs;
         sqs      = q24_ff[i] * q24_ff[i];
         sq_in[i] = sqs[57:0];
      end
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            pl_in[r*3+j] = m_ff[r*3+j] * $signed({1'b0, tv_ff[j][19:0]});
            ph_in[r*3+j] = m_ff[r*3+j] * $signed(tv_ff[j][39:20]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sq_ff <= sq_in;
         pl_ff <= pl_in;
         ph_ff <= ph_in;
      end
   end

   // stage 3: length squared and matrix rows
   always_comb begin
      ssum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = '0;
         for (int j = 0; j < 3; j++) begin
            acc_in[r] = acc_in[r] + (64'(ph_ff[r*3+j]) <<< 20) + 64'(pl_ff[r*3+j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ssum_ff <= ssum_in;
         acc_ff  <= acc_in;
      end
   end

   // side payload carried down the pipe
   always_comb begin
      carry_in[CARRY_FIRST].wt  = '0;
      carry_in[CARRY_FIRST].big = 1'b0;
      for (int i = 0; i < 3; i++) carry_in[CARRY_FIRST].ws[i] = ws_ff[i];
      for (int i = 0; i < 4; i++) begin
         logic [29:0] ab;
         ab = q24_ff[i][29] ? 30'(-q24_ff[i]) : 30'(q24_ff[i]);
         carry_in[CARRY_FIRST].qmag[i] = ab[QMAG_W-1:0];
         carry_in[CARRY_FIRST].qneg[i] = q24_ff[i][29];
         carry_in[CARRY_FIRST].qa[i]   = sat16(rnd_shr(64'(q24_ff[i]), 10));
      end
      for (int s = CARRY_FIRST + 1; s <= OUT_ST; s++) carry_in[s] = carry_ff[s-1];
      for (int r = 0; r < 3; r++) begin
         carry_in[TRANS_ST].wt[r] = sat32(rnd_shr(acc_ff[r], 18) + 64'(pt[r]));
      end
      carry_in[PREP_ST].big = root > ZERO_TOL;
   end

   always_ff @(posedge clock) begin
      for (int s = CARRY_FIRST; s <= OUT_ST; s++) begin
         if (en[s]) carry_ff[s] <= carry_in[s];
      end
   end

   trs_isqrt u_isqrt (
      .clock (clock),
      .en    (en[SQ_FIRST +: NSQ]),
      .x     (ssum_ff),
      .root  (root)
   );

   // divider operands: rounded dividend and length
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dd_in[i] = (DD_W'(carry_ff[PREP_ST-1].qmag[i]) << 14) + DD_W'(root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[PREP_ST]) begin
         dd_ff  <= dd_in;
         len_ff <= root;
      end
   end

   trs_qdiv u_qdiv (
      .clock (clock),
      .en    (en[DIV_FIRST +: NDIV]),
      .dd    (dd_ff),
      .len   (len_ff),
      .quo   (quo)
   );

   // output stage
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [15:0] qv;
         qv = {1'b0, quo[i]};
         if (carry_ff[OUT_ST-1].big) begin
            wq_in[i] = carry_ff[OUT_ST-1].qneg[i] ? 16'(-qv) : qv;
         end else begin
            wq_in[i] = carry_ff[OUT_ST-1].qa[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT_ST]) wq_ff <= wq_in;
   end

   assign rsp_world_tx = $signed(carry_ff[OUT_ST].wt[0]);
   assign rsp_world_ty = $signed(carry_ff[OUT_ST].wt[1]);
   assign rsp_world_tz = $signed(carry_ff[OUT_ST].wt[2]);
   assign rsp_world_qx = $signed(wq_ff[0]);
   assign rsp_world_qy = $signed(wq_ff[1]);
   assign rsp_world_qz = $signed(wq_ff[2]);
   assign rsp_world_qw = $signed(wq_ff[3]);
   assign rsp_world_sx = $signed(carry_ff[OUT_ST].ws[0]);
   assign rsp_world_sy = $signed(carry_ff[OUT_ST].ws[1]);
   assign rsp_world_sz = $signed(carry_ff[OUT_ST].ws[2]);

endmodule

// ===== rtl/trs_check.sv =====
// ----------------------------------------------------------------------------
// trs_check: port-level checks for the transform compose block
// Watches handshake, reset and flow behavior at the top-level ports.
// ----------------------------------------------------------------------------
module trs_check (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               pready,
   input logic signed [31:0] rsp_world_tx,
   input logic signed [15:0] rsp_world_qw
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled transaction dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_world_tx) && $stable(rsp_world_qw))
      else $error("stalled transaction changed");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind trs_transform_compose trs_check u_trs_check (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: trs_transform_compose
// Drives child transforms against several parent settings written over APB,
// predicts each world transform in fixed point or takes it from a directed
// row, and checks every result transaction in order, partly under random
// idling on both channels and with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import trs_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] t;
      logic [3:0][15:0] q;
      logic [2:0][15:0] s;
   } xform_type;

   typedef struct {
      xform_type child;
      bit        has_world;
      xform_type world;
   } dir_row_type;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_child_tx = '0, req_child_ty = '0, req_child_tz = '0;
   logic signed [15:0] req_child_qx = '0, req_child_qy = '0, req_child_qz = '0;
   logic signed [15:0] req_child_qw = '0;
   logic signed [15:0] req_child_sx = '0, req_child_sy = '0, req_child_sz = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_world_tx, rsp_world_ty, rsp_world_tz;
   logic signed [15:0] rsp_world_qx, rsp_world_qy, rsp_world_qz, rsp_world_qw;
   logic signed [15:0] rsp_world_sx, rsp_world_sy, rsp_world_sz;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [5:0]         paddr = '0;
   logic [63:0]        pwdata = '0;
   logic [63:0]        prdata;
   logic               pready;

   trs_transform_compose dut (.*);

   logic [2:0][31:0] par_t;
   logic [3:0][15:0] par_q;
   logic [47:0]      par_scale;

   xform_type  world_queue[$];
   int         mismatches = 0;
   int         cycles = 0;
   int         send_idle = 0;
   int         recv_idle = 0;
   bit         holdoff_req = 0;
   int         holdoff_left = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("trs_transform_compose verification failed");
         $finish;
      end
   end

   function automatic longint rnd(longint v, int s);
      longint unsigned mag;
      mag = v < 0 ? longint'(-v) : v;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint satw(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic xform_type compose_world(xform_type c);
      longint p[4], k[4], q24[4], pt[3], ps[3], ct[3], cs[3], tv[3], m[9];
      longint acc, r;
      longint unsigned sum, len, bitv, x, um;
      xform_type w;
      for (int i = 0; i < 4; i++) begin
         p[i] = $signed(par_q[i]);
         k[i] = $signed(c.q[i]);
      end
      for (int i = 0; i < 3; i++) begin
         pt[i] = $signed(par_t[i]);
         ps[i] = $signed(par_scale[16*i +: 16]);
         ct[i] = $signed(c.t[i]);
         cs[i] = $signed(c.s[i]);
      end
      q24[0] = rnd(p[0]*k[3] + k[0]*p[3] + p[1]*k[2] - p[2]*k[1], 4);
      q24[1] = rnd(p[1]*k[3] + k[1]*p[3] + p[2]*k[0] - p[0]*k[2], 4);
      q24[2] = rnd(p[2]*k[3] + k[2]*p[3] + p[0]*k[1] - p[1]*k[0], 4);
      q24[3] = rnd(p[3]*k[3] - (p[0]*k[0] + p[1]*k[1] + p[2]*k[2]), 4);
      sum = 0;
      for (int i = 0; i < 4; i++) sum += longint'(q24[i] * q24[i]);
      x = sum;
      len = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= len + bitv) begin
            x -= len + bitv;
            len = (len >> 1) + bitv;
         end else begin
            len >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 4; i++) begin
         if (len > 17) begin
            um = q24[i] < 0 ? longint'(-q24[i]) : q24[i];
            um = ((um << 14) + (len >> 1)) / len;
            r = q24[i] < 0 ? -longint'(um) : longint'(um);
         end else begin
            r = rnd(q24[i], 10);
         end
         w.q[i] = 16'(satw(r, 16));
      end
      for (int i = 0; i < 3; i++) w.s[i] = 16'(satw(rnd(ps[i] * cs[i], 8), 16));
      m[0] = ONE_Q28 - 2 * (p[1]*p[1] + p[2]*p[2]);
      m[1] = 2 * (p[0]*p[1] - p[3]*p[2]);
      m[2] = 2 * (p[0]*p[2] + p[3]*p[1]);
      m[3] = 2 * (p[0]*p[1] + p[3]*p[2]);
      m[4] = ONE_Q28 - 2 * (p[0]*p[0] + p[2]*p[2]);
      m[5] = 2 * (p[1]*p[2] - p[3]*p[0]);
      m[6] = 2 * (p[0]*p[2] - p[3]*p[1]);
      m[7] = 2 * (p[1]*p[2] + p[3]*p[0]);
      m[8] = ONE_Q28 - 2 * (p[0]*p[0] + p[1]*p[1]);
      for (int i = 0; i < 9; i++) m[i] = rnd(m[i], 10);
      for (int i = 0; i < 3; i++) tv[i] = rnd(ct[i] * ps[i], 8);
      for (int i = 0; i < 3; i++) begin
         acc = m[3*i] * tv[0] + m[3*i+1] * tv[1] + m[3*i+2] * tv[2];
         w.t[i] = 32'(satw(rnd(acc, 18) + pt[i], 32));
      end
      return w;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_PTX, REG_PTY, REG_PTZ: par_t[idx] = value[31:0];
         REG_PSCALE:                par_scale = value[47:0];
         default:                   par_q[idx - REG_PQX] = value[15:0];
      endcase
   endtask

   task automatic load_parent(logic [2:0][31:0] t, logic [3:0][15:0] q, logic [47:0] s);
      for (int i = 0; i < 3; i++) csr_write(REG_PTX + 3'(i), 64'(t[i]));
      for (int i = 0; i < 4; i++) csr_write(REG_PQX + 3'(i), 64'(q[i]));
      csr_write(REG_PSCALE, 64'(s));
   endtask

   task automatic drain;
      while (world_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_child(xform_type c, xform_type world);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_child_tx <= c.t[0];
      req_child_ty <= c.t[1];
      req_child_tz <= c.t[2];
      req_child_qx <= c.q[0];
      req_child_qy <= c.q[1];
      req_child_qz <= c.q[2];
      req_child_qw <= c.q[3];
      req_child_sx <= c.s[0];
      req_child_sy <= c.s[1];
      req_child_sz <= c.s[2];
      req_valid    <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      world_queue.push_back(world);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(2000)) - 1000);
         3: return 32'(signed'($urandom_range(65535)) - 32768) <<< 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick16(bit tiny);
      if (tiny) return 16'($signed($urandom_range(8)) - 4);
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic xform_type random_child();
      xform_type c;
      bit tiny;
      tiny = ($urandom_range(9) == 0);
      for (int i = 0; i < 3; i++) c.t[i] = pick32();
      for (int i = 0; i < 4; i++) c.q[i] = pick16(tiny);
      for (int i = 0; i < 3; i++) c.s[i] = pick16(1'b0);
      return c;
   endfunction

   function automatic xform_type mk(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                    logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                    logic [15:0] qw, logic [15:0] sx, logic [15:0] sy,
                                    logic [15:0] sz);
      xform_type c;
      c.t = {tz, ty, tx};
      c.q = {qw, qz, qy, qx};
      c.s = {sz, sy, sx};
      return c;
   endfunction

   function automatic bit check_field(string name, logic [31:0] exp_v, logic [31:0] act_v,
                                      bit report);
      if (exp_v !== act_v) begin
         if (report)
            $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      xform_type exp_w;
      bit ok, rep;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (world_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result transaction with none expected");
         end else begin
            exp_w = world_queue.pop_front();
            rep = (mismatches < 10);
            ok = 1'b1;
            ok &= check_field("world_tx", exp_w.t[0], rsp_world_tx, rep);
            ok &= check_field("world_ty", exp_w.t[1], rsp_world_ty, rep);
            ok &= check_field("world_tz", exp_w.t[2], rsp_world_tz, rep);
            ok &= check_field("world_qx", 32'(exp_w.q[0]), 32'($unsigned(rsp_world_qx)), rep);
            ok &= check_field("world_qy", 32'(exp_w.q[1]), 32'($unsigned(rsp_world_qy)), rep);
            ok &= check_field("world_qz", 32'(exp_w.q[2]), 32'($unsigned(rsp_world_qz)), rep);
            ok &= check_field("world_qw", 32'(exp_w.q[3]), 32'($unsigned(rsp_world_qw)), rep);
            ok &= check_field("world_sx", 32'(exp_w.s[0]), 32'($unsigned(rsp_world_sx)), rep);
            ok &= check_field("world_sy", 32'(exp_w.s[1]), 32'($unsigned(rsp_world_sy)), rep);
            ok &= check_field("world_sz", 32'(exp_w.s[2]), 32'($unsigned(rsp_world_sz)), rep);
            if (!ok) mismatches++;
         end
      end
      if (holdoff_req) begin
         holdoff_req = 0;
         holdoff_left = 400;
      end
      if (holdoff_left > 0) holdoff_left--;
      rsp_stall <= (holdoff_left > 0) || ($urandom_range(99) < recv_idle);
   end

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      xform_type c, w0;
      logic [2:0][31:0] pt;
      logic [3:0][15:0] pq;
      logic [47:0] ps;

      par_t = '0;
      par_q = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
      par_scale = 48'h010001000100;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      w0 = mk(0, 0, 0, 0, 0, 0, 16'h4000, 16'h0100, 16'h0100, 16'h0100);
      rows.push_back('{w0, 1'b1, w0});
      w0 = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      rows.push_back('{w0, 1'b1, w0});
      w0 = mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 16'h4000, 16'h0100, 16'h0100, 16'h0100);
      rows.push_back('{w0, 1'b1, w0});
      rows.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0, w0});
      rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0, w0});
      rows.push_back('{mk(1, 32'hffffffff, 2, 1, 0, 0, 0, 1, 16'hffff, 0), 1'b0, w0});
      rows.push_back('{mk(0, 0, 0, 2, 2, 2, 2, 0, 0, 0), 1'b0, w0});
      rows.push_back('{mk(0, 0, 0, 5, 0, 0, 16'hfffb, 0, 0, 0), 1'b0, w0});
      rows.push_back('{mk(32'h00010000, 0, 0, 0, 16'h2d41, 0, 16'h2d41, 16'h0200, 16'h0080,
                          16'hff00), 1'b0, w0});
      rows.push_back('{mk(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 16'h1234, 16'h8765,
                          16'h5555, 16'haaaa, 16'h7f00, 16'h80ff, 16'h0001), 1'b0, w0});

      send_idle = 25;
      recv_idle = 57;
      foreach (rows[i]) begin
         row = rows[i];
         send_child(row.child, row.has_world ? row.world : compose_world(row.child));
      end
      req_valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               pt = {3{32'h7fffffff}};
               pq = {4{16'h7fff}};
               ps = {3{16'h7fff}};
            end
            1: begin
               pt = {3{32'h80000000}};
               pq = {4{16'h8000}};
               ps = {3{16'h8000}};
            end
            3: begin
               for (int i = 0; i < 3; i++) pt[i] = $urandom;
               for (int i = 0; i < 4; i++) pq[i] = pick16(1'b1);
               ps = 48'({$urandom, $urandom});
            end
            5: begin
               pt = '0;
               pq = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
               ps = 48'h010001000100;
            end
            default: begin
               for (int i = 0; i < 3; i++) pt[i] = pick32();
               for (int i = 0; i < 4; i++) pq[i] = pick16(1'b0);
               for (int i = 0; i < 3; i++) ps[16*i +: 16] = pick16(1'b0);
            end
         endcase
         load_parent(pt, pq, ps);
         send_idle = (ph < 2) ? 25 : (ph < 4) ? 57 : 0;
         recv_idle = (ph < 2) ? 57 : (ph < 4) ? 25 : 0;
         if (ph == 4) holdoff_req = 1;
         for (int n = 0; n < 100; n++) begin
            c = random_child();
            send_child(c, compose_world(c));
         end
         req_valid <= 1'b0;
         drain();
      end

      repeat (60) @(posedge clock);
      if (mismatches == 0 && world_queue.size() == 0) begin
         $display("trs_transform_compose verification clean");
      end else begin
         $display("trs_transform_compose verification failed");
      end
      $finish;
   end

endmodule
